### hdl/kfq_pkg.sv
// Package for the keyed FIFO queue: action and status codes, default sizes,
// and the control struct between the sequencer and the tally unit.
// No dependencies.
package kfq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int QueueDepthDef = 16;
  localparam int KeyBitsDef    = 16;
  localparam int ValueBitsDef  = 32;

  localparam int ActionW = 3;
  localparam int StatusW = 2;

  // Action codes; the two unused codes behave as a query.
  localparam logic [ActionW-1:0] ACT_PUSH     = 3'd0;
  localparam logic [ActionW-1:0] ACT_POP      = 3'd1;
  localparam logic [ActionW-1:0] ACT_POP_KEY  = 3'd2;
  localparam logic [ActionW-1:0] ACT_MOVE_KEY = 3'd3;
  localparam logic [ActionW-1:0] ACT_CLEAR    = 3'd4;
  localparam logic [ActionW-1:0] ACT_QUERY    = 3'd5;

  // Status codes reported with every result.
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] ST_MISSING = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd3;

  // Sequencer to tally unit: clear the statistics, or count one entry of
  // the queue as it is rebuilt in order.
  typedef struct packed {
    logic start;
    logic take;
  } kfq_tally_ctl_t;

endpackage

### hdl/keyed_fifo_queue_unit.sv
// Keyed FIFO queue: bounded queue of key/value entries in arrival order.
// Holds the sequencer and output register; uses kfq_pkg, kfq_store, kfq_tally.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o) carries one action with a key
//   and a value per transaction. The output channel (out_valid_o,
//   out_stall_i) returns exactly one result per action: status, occupancy,
//   the front and back entries, and the count, oldest and newest values of
//   the given key after the action.
//   Every action but clear rewrites the queue in place through the entry
//   memory, one entry per cycle on its single read port, while the tally
//   unit compares each entry with the key. The action first scans the live
//   entries, then in a tail step appends the pushed entry or reads back the
//   moved entries of the key from a parked area, and finally registers the
//   result in the wrap step; clear goes straight to the wrap step. One action
//   is in work at a time, and the next transaction can be taken in the cycle
//   the result appears, also while that result still waits in the output
//   register. When the receiver stalls and an older result is still held,
//   the new result waits in the sequencer until the slot frees.
//   Reset empties the queue and drops any held result; the entry memory is
//   not cleared: only live slots and those parked by the action are read.
module keyed_fifo_queue_unit #(
  parameter int QUEUE_DEPTH = kfq_pkg::QueueDepthDef,
  parameter int KEY_BITS    = kfq_pkg::KeyBitsDef,
  parameter int VALUE_BITS  = kfq_pkg::ValueBitsDef,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kfq_pkg::ActionW-1:0]  action_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kfq_pkg::StatusW-1:0]  status_o,
  output logic [CNT_W-1:0]             occupancy_o,
  output logic [KEY_BITS-1:0]          front_key_o,
  output logic [VALUE_BITS-1:0]        front_value_o,
  output logic [KEY_BITS-1:0]          back_key_o,
  output logic [VALUE_BITS-1:0]        back_value_o,
  output logic [CNT_W-1:0]             key_count_o,
  output logic [VALUE_BITS-1:0]        key_first_value_o,
  output logic [VALUE_BITS-1:0]        key_last_value_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int AW = IW + 1;
  localparam int DW = KEY_BITS + VALUE_BITS;
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_WRAP
  } state_e;

  state_e                      state_q;
  logic [kfq_pkg::ActionW-1:0] act_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [VALUE_BITS-1:0]       val_q;
  logic [CNT_W-1:0]            n_q, rd_q, w_q, m_q;
  logic [IW-1:0]               pos_q;
  logic                        dv_q, removed_q, full_q, empty_q;

  logic                        out_valid_q;
  logic [kfq_pkg::StatusW-1:0] status_q;
  logic [CNT_W-1:0]            occ_q, kcnt_q;
  logic [KEY_BITS-1:0]         fkey_q, bkey_q;
  logic [VALUE_BITS-1:0]       fval_q, bval_q, kfirst_q, klast_q;

  logic                        accept, out_free;
  logic                        is_push, is_pop, is_pop_key, is_move;
  logic                        rd_en, scan_data, drop, to_temp, keep;
  logic                        tail_move, tail_push;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [KEY_BITS-1:0]         wr_key, ent_key, rd_key;
  logic [VALUE_BITS-1:0]       wr_val, ent_val, rd_val;
  logic [DW-1:0]               rd_data;
  logic                        match;
  kfq_pkg::kfq_tally_ctl_t     tally_ctl;
  logic [kfq_pkg::StatusW-1:0] status_d;

  logic [KEY_BITS-1:0]         t_fkey, t_bkey;
  logic [VALUE_BITS-1:0]       t_fval, t_bval, t_first, t_last;
  logic [CNT_W-1:0]            t_cnt;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign is_push    = (act_q == kfq_pkg::ACT_PUSH);
  assign is_pop     = (act_q == kfq_pkg::ACT_POP);
  assign is_pop_key = (act_q == kfq_pkg::ACT_POP_KEY);
  assign is_move    = (act_q == kfq_pkg::ACT_MOVE_KEY);

  assign rd_key = rd_data[DW-1:VALUE_BITS];
  assign rd_val = rd_data[VALUE_BITS-1:0];

  // Read side: the live slots during the scan, the parked slots in the tail.
  always_comb begin
    rd_en = 1'b0;
    if (state_q == S_SCAN) begin
      rd_en = (rd_q < n_q);
    end else if (state_q == S_TAIL && is_move) begin
      rd_en = (rd_q < m_q);
    end
  end
  assign rd_addr = {state_q == S_TAIL, rd_q[IW-1:0]};

  // Decision for the entry that arrived from memory during the scan.
  assign scan_data = (state_q == S_SCAN) && dv_q;
  assign drop      = is_pop ? (pos_q == '0) : (is_pop_key && match && !removed_q);
  assign to_temp   = is_move && match;
  assign keep      = !drop && !to_temp;
  assign tail_move = (state_q == S_TAIL) && is_move && dv_q;
  assign tail_push = (state_q == S_TAIL) && is_push && !full_q;

  // Write side and the entry shown to the tally unit.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = {1'b0, w_q[IW-1:0]};
    wr_key    = key_q;
    wr_val    = rd_val;
    tally_ctl = '{start: accept, take: 1'b0};
    ent_key   = rd_key;
    ent_val   = rd_val;
    if (state_q == S_TAIL) begin
      ent_key = key_q;
      ent_val = is_move ? rd_val : val_q;
    end
    if (scan_data) begin
      if (to_temp) begin
        wr_en   = 1'b1;
        wr_addr = {1'b1, m_q[IW-1:0]};
      end else if (keep) begin
        wr_en          = 1'b1;
        wr_key         = rd_key;
        tally_ctl.take = 1'b1;
      end
    end else if (tail_move) begin
      wr_en          = 1'b1;
      tally_ctl.take = 1'b1;
    end else if (tail_push) begin
      wr_en          = 1'b1;
      wr_val         = val_q;
      tally_ctl.take = 1'b1;
    end
  end

  // Final status of the action in work.
  always_comb begin
    case (act_q)
      kfq_pkg::ACT_PUSH:     status_d = full_q ? kfq_pkg::ST_FULL : kfq_pkg::ST_OK;
      kfq_pkg::ACT_POP:      status_d = empty_q ? kfq_pkg::ST_EMPTY : kfq_pkg::ST_OK;
      kfq_pkg::ACT_POP_KEY:  status_d = removed_q ? kfq_pkg::ST_OK : kfq_pkg::ST_MISSING;
      kfq_pkg::ACT_MOVE_KEY: status_d = (m_q != '0) ? kfq_pkg::ST_OK : kfq_pkg::ST_MISSING;
      default:               status_d = kfq_pkg::ST_OK;
    endcase
  end

  kfq_store #(
    .ADDR_W(AW),
    .DATA_W(DW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i({wr_key, wr_val}),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  kfq_tally #(
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS),
    .CNT_W     (CNT_W)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (tally_ctl),
    .query_key_i(key_q),
    .ent_key_i  (ent_key),
    .ent_val_i  (ent_val),
    .match_o    (match),
    .front_key_o(t_fkey),
    .front_val_o(t_fval),
    .back_key_o (t_bkey),
    .back_val_o (t_bval),
    .count_o    (t_cnt),
    .first_val_o(t_first),
    .last_val_o (t_last)
  );

  // Sequencer with its counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= kfq_pkg::ACT_QUERY;
      n_q         <= '0;
      rd_q        <= '0;
      w_q         <= '0;
      m_q         <= '0;
      pos_q       <= '0;
      dv_q        <= 1'b0;
      removed_q   <= 1'b0;
      full_q      <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result frees the slot, unless a new result refills it now.
      if (out_valid_q && !out_stall_i && state_q != S_WRAP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q     <= action_i;
            key_q     <= key_i;
            val_q     <= value_i;
            rd_q      <= '0;
            w_q       <= '0;
            m_q       <= '0;
            dv_q      <= 1'b0;
            removed_q <= 1'b0;
            full_q    <= (n_q == DepthC);
            empty_q   <= (n_q == '0);
            state_q   <= (action_i == kfq_pkg::ACT_CLEAR) ? S_WRAP : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_q <= rd_q + CNT_W'(1);
          end
          dv_q  <= rd_en;
          pos_q <= rd_q[IW-1:0];
          if (scan_data) begin
            if (drop) begin
              removed_q <= 1'b1;
            end else if (to_temp) begin
              m_q <= m_q + CNT_W'(1);
            end else begin
              w_q <= w_q + CNT_W'(1);
            end
          end
          if (!rd_en && !dv_q) begin
            rd_q    <= '0;
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (is_move) begin
            if (rd_en) begin
              rd_q <= rd_q + CNT_W'(1);
            end
            dv_q <= rd_en;
            if (tail_move) begin
              w_q <= w_q + CNT_W'(1);
            end
            if (!rd_en && !dv_q) begin
              state_q <= S_WRAP;
            end
          end else begin
            if (tail_push) begin
              w_q <= w_q + CNT_W'(1);
            end
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (out_free) begin
            n_q         <= w_q;
            out_valid_q <= 1'b1;
            status_q    <= status_d;
            occ_q       <= w_q;
            fkey_q      <= t_fkey;
            fval_q      <= t_fval;
            bkey_q      <= t_bkey;
            bval_q      <= t_bval;
            kcnt_q      <= t_cnt;
            kfirst_q    <= t_first;
            klast_q     <= t_last;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign occupancy_o       = occ_q;
  assign front_key_o       = fkey_q;
  assign front_value_o     = fval_q;
  assign back_key_o        = bkey_q;
  assign back_value_o      = bval_q;
  assign key_count_o       = kcnt_q;
  assign key_first_value_o = kfirst_q;
  assign key_last_value_o  = klast_q;

  // The stored entry count never goes past the capacity.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= DepthC)
    else $error("entry count exceeds queue depth");

  // A refused push is only reported when the queue is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == kfq_pkg::ST_FULL |-> occ_q == DepthC)
    else $error("full status with free space");

  // An empty queue reports no entries and no key matches.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && occ_q == '0 |->
      fkey_q == '0 && bkey_q == '0 && kcnt_q == '0 && klast_q == '0)
    else $error("empty queue reports stale entries");

  // The key count can never exceed the occupancy.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> kcnt_q <= occ_q)
    else $error("key count above occupancy");

  // In-place compaction never writes ahead of the slot being read back.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_data && keep |-> w_q[IW-1:0] <= pos_q)
    else $error("compaction write overtakes read");

endmodule

### hdl/kfq_store.sv
// Entry memory of the keyed FIFO queue: one write port and one read port
// with registered read data. Depends on kfq_pkg for default widths only.
module kfq_store #(
  parameter int ADDR_W = $clog2(kfq_pkg::QueueDepthDef) + 1,
  parameter int DATA_W = kfq_pkg::KeyBitsDef + kfq_pkg::ValueBitsDef
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int Depth = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/kfq_tally.sv
// Shared key compare and statistics unit of the keyed FIFO queue. It watches
// the entries as the queue is rewritten in order. Depends on kfq_pkg.
module kfq_tally #(
  parameter int KEY_BITS   = kfq_pkg::KeyBitsDef,
  parameter int VALUE_BITS = kfq_pkg::ValueBitsDef,
  parameter int CNT_W      = $clog2(kfq_pkg::QueueDepthDef + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kfq_pkg::kfq_tally_ctl_t ctl_i,
  input  logic [KEY_BITS-1:0]    query_key_i,
  input  logic [KEY_BITS-1:0]    ent_key_i,
  input  logic [VALUE_BITS-1:0]  ent_val_i,
  output logic                   match_o,
  output logic [KEY_BITS-1:0]    front_key_o,
  output logic [VALUE_BITS-1:0]  front_val_o,
  output logic [KEY_BITS-1:0]    back_key_o,
  output logic [VALUE_BITS-1:0]  back_val_o,
  output logic [CNT_W-1:0]       count_o,
  output logic [VALUE_BITS-1:0]  first_val_o,
  output logic [VALUE_BITS-1:0]  last_val_o
);

  logic                  any_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [KEY_BITS-1:0]   front_key_q, back_key_q;
  logic [VALUE_BITS-1:0] front_val_q, back_val_q, first_val_q, last_val_q;

  // The one key comparator, used for removal and move decisions and for the count.
  assign match_o = (ent_key_i == query_key_i);

  // Control part of the statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
      cnt_q <= '0;
    end else if (ctl_i.start) begin
      any_q <= 1'b0;
      cnt_q <= '0;
    end else if (ctl_i.take) begin
      any_q <= 1'b1;
      if (match_o) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Captured entries; everything reads as zero until an entry is seen.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      front_key_q <= '0;
      front_val_q <= '0;
      back_key_q  <= '0;
      back_val_q  <= '0;
      first_val_q <= '0;
      last_val_q  <= '0;
    end else if (ctl_i.take) begin
      if (!any_q) begin
        front_key_q <= ent_key_i;
        front_val_q <= ent_val_i;
      end
      back_key_q <= ent_key_i;
      back_val_q <= ent_val_i;
      if (match_o) begin
        if (cnt_q == '0) begin
          first_val_q <= ent_val_i;
        end
        last_val_q <= ent_val_i;
      end
    end
  end

  assign front_key_o = front_key_q;
  assign front_val_o = front_val_q;
  assign back_key_o  = back_key_q;
  assign back_val_o  = back_val_q;
  assign count_o     = cnt_q;
  assign first_val_o = first_val_q;
  assign last_val_o  = last_val_q;

endmodule

### dv/tb_keyed_fifo_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_fifo_queue_unit: a directed table, then random
// action streams, checked against a predictor or a typed row's view. Depends on kfq_pkg and the RTL.
module tb_keyed_fifo_queue_unit;

  localparam int DEPTH = kfq_pkg::QueueDepthDef;
  localparam int KW    = kfq_pkg::KeyBitsDef;
  localparam int VW    = kfq_pkg::ValueBitsDef;
  localparam int CW    = $clog2(DEPTH + 1);

  // The two spare action codes, which the block treats as a query.
  localparam logic [kfq_pkg::ActionW-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [kfq_pkg::ActionW-1:0] ACT_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 930;
  localparam int PHASE_LEN    = 40;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

  // Everything one result reports about the queue after an action.
  typedef struct packed {
    logic [kfq_pkg::StatusW-1:0] status;
    logic [CW-1:0]               occupancy;
    logic [KW-1:0]               front_key;
    logic [VW-1:0]               front_value;
    logic [KW-1:0]               back_key;
    logic [VW-1:0]               back_value;
    logic [CW-1:0]               key_count;
    logic [VW-1:0]               key_first_value;
    logic [VW-1:0]               key_last_value;
  } queue_view_t;

  // One directed row; the typed view is used only when typed is set.
  typedef struct packed {
    logic [kfq_pkg::ActionW-1:0] action;
    logic [KW-1:0]               key;
    logic [VW-1:0]               value;
    logic                        typed;
    queue_view_t                 view;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [kfq_pkg::ActionW-1:0] action_i;
  logic [KW-1:0]               key_i;
  logic [VW-1:0]               value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [kfq_pkg::StatusW-1:0] status_o;
  logic [CW-1:0]               occupancy_o;
  logic [KW-1:0]               front_key_o;
  logic [VW-1:0]               front_value_o;
  logic [KW-1:0]               back_key_o;
  logic [VW-1:0]               back_value_o;
  logic [CW-1:0]               key_count_o;
  logic [VW-1:0]               key_first_value_o;
  logic [VW-1:0]               key_last_value_o;

  keyed_fifo_queue_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .key_i             (key_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .occupancy_o       (occupancy_o),
    .front_key_o       (front_key_o),
    .front_value_o     (front_value_o),
    .back_key_o        (back_key_o),
    .back_value_o      (back_value_o),
    .key_count_o       (key_count_o),
    .key_first_value_o (key_first_value_o),
    .key_last_value_o  (key_last_value_o)
  );

  // Mirror of the queue contents, oldest entry in slot 0.
  logic [KW-1:0] mirror_keys   [DEPTH];
  logic [VW-1:0] mirror_values [DEPTH];
  int            mirror_fill;

  queue_view_t pending_views [$];
  stim_row_t   stim_rows [$];

  int  fail_count;
  int  actions_sent;
  int  results_checked;
  int  full_refusals;
  int  key_misses;
  int  empty_pops;
  int  moves_done;
  bit  source_calm;
  int  results_drained;

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Remove one slot and close the gap behind it.
  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < mirror_fill; i++) begin
      mirror_keys[i]   = mirror_keys[i + 1];
      mirror_values[i] = mirror_values[i + 1];
    end
    mirror_fill--;
  endfunction

  // Apply one action to the mirror and return the view the block must report.
  function automatic queue_view_t apply_action(input logic [kfq_pkg::ActionW-1:0] act,
                                               input logic [KW-1:0] k,
                                               input logic [VW-1:0] v);
    queue_view_t   view;
    logic [VW-1:0] moved [DEPTH];
    int            hit;
    int            w;
    int            m;
    view = '0;
    view.status = kfq_pkg::ST_OK;
    hit = -1;
    w = 0;
    m = 0;
    case (act)
      kfq_pkg::ACT_PUSH: begin
        if (mirror_fill >= DEPTH) begin
          view.status = kfq_pkg::ST_FULL;
        end else begin
          mirror_keys[mirror_fill]   = k;
          mirror_values[mirror_fill] = v;
          mirror_fill++;
        end
      end
      kfq_pkg::ACT_POP: begin
        if (mirror_fill == 0) view.status = kfq_pkg::ST_EMPTY;
        else drop_slot(0);
      end
      kfq_pkg::ACT_POP_KEY: begin
        for (int i = 0; i < mirror_fill; i++) begin
          if (hit < 0 && mirror_keys[i] == k) hit = i;
        end
        if (hit < 0) view.status = kfq_pkg::ST_MISSING;
        else drop_slot(hit);
      end
      kfq_pkg::ACT_MOVE_KEY: begin
        // Compact the other entries forward, then append the keyed ones in order.
        for (int i = 0; i < mirror_fill; i++) begin
          if (mirror_keys[i] == k) begin
            moved[m] = mirror_values[i];
            m++;
          end else begin
            mirror_keys[w]   = mirror_keys[i];
            mirror_values[w] = mirror_values[i];
            w++;
          end
        end
        if (m == 0) begin
          view.status = kfq_pkg::ST_MISSING;
        end else begin
          for (int i = 0; i < m; i++) begin
            mirror_keys[w + i]   = k;
            mirror_values[w + i] = moved[i];
          end
        end
      end
      kfq_pkg::ACT_CLEAR: mirror_fill = 0;
      default: ;
    endcase

    // Summarize the queue after the action.
    view.occupancy = CW'(mirror_fill);
    if (mirror_fill > 0) begin
      view.front_key   = mirror_keys[0];
      view.front_value = mirror_values[0];
      view.back_key    = mirror_keys[mirror_fill - 1];
      view.back_value  = mirror_values[mirror_fill - 1];
    end
    for (int i = 0; i < mirror_fill; i++) begin
      if (mirror_keys[i] == k) begin
        if (view.key_count == 0) view.key_first_value = mirror_values[i];
        view.key_last_value = mirror_values[i];
        view.key_count++;
      end
    end
    return view;
  endfunction

  function automatic queue_view_t view_of(input logic [kfq_pkg::StatusW-1:0] st,
                                          input int occ,
                                          input logic [KW-1:0] fk, input logic [VW-1:0] fv,
                                          input logic [KW-1:0] bk, input logic [VW-1:0] bv,
                                          input int cnt, input logic [VW-1:0] first,
                                          input logic [VW-1:0] last);
    queue_view_t view;
    view.status          = st;
    view.occupancy       = CW'(occ);
    view.front_key       = fk;
    view.front_value     = fv;
    view.back_key        = bk;
    view.back_value      = bv;
    view.key_count       = CW'(cnt);
    view.key_first_value = first;
    view.key_last_value  = last;
    return view;
  endfunction

  function automatic void add_row(input logic [kfq_pkg::ActionW-1:0] act,
                                  input logic [KW-1:0] k,
                                  input logic [VW-1:0] v, input logic typed,
                                  input queue_view_t view);
    stim_row_t row;
    row.action = act;
    row.key    = k;
    row.value  = v;
    row.typed  = typed;
    row.view   = view;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Weighted action choice; a filling phase leans on push, a draining one on removal.
  function automatic logic [kfq_pkg::ActionW-1:0] pick_action(input bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 60) return kfq_pkg::ACT_PUSH;
      if (roll < 70) return kfq_pkg::ACT_POP;
      if (roll < 80) return kfq_pkg::ACT_POP_KEY;
      if (roll < 90) return kfq_pkg::ACT_MOVE_KEY;
      if (roll < 97) return kfq_pkg::ACT_QUERY;
      if (roll < 98) return kfq_pkg::ACT_CLEAR;
    end else begin
      if (roll < 20) return kfq_pkg::ACT_PUSH;
      if (roll < 50) return kfq_pkg::ACT_POP;
      if (roll < 75) return kfq_pkg::ACT_POP_KEY;
      if (roll < 85) return kfq_pkg::ACT_MOVE_KEY;
      if (roll < 95) return kfq_pkg::ACT_QUERY;
      if (roll < 97) return kfq_pkg::ACT_CLEAR;
    end
    return ($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
  endfunction

  // Present one transaction after a random gap (none while the source is calm) and hold it until it is taken.
  task automatic send_action(input logic [kfq_pkg::ActionW-1:0] act,
                             input logic [KW-1:0] k,
                             input logic [VW-1:0] v, input logic typed,
                             input queue_view_t typed_view);
    int          gap;
    queue_view_t view;
    gap = source_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    view = apply_action(act, k, v);
    if (view.status == kfq_pkg::ST_FULL) full_refusals++;
    if (view.status == kfq_pkg::ST_MISSING) key_misses++;
    if (view.status == kfq_pkg::ST_EMPTY) empty_pops++;
    if (act == kfq_pkg::ACT_MOVE_KEY && view.status == kfq_pkg::ST_OK) moves_done++;
    pending_views.insert(pending_views.size(), typed ? typed_view : view);
    actions_sent++;
  endtask

  // Result sink: stall randomly before taking each result, but never in every fourth run of fifty results.
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    results_drained = 0;
    @(posedge rst_ni);
    forever begin
      hold = ((results_drained / 50) % 4 == 3) ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      results_drained++;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    queue_view_t exp_view;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        $error("result with no transaction outstanding: status %0d occupancy %0d",
               status_o, occupancy_o);
        fail_count++;
      end else begin
        exp_view = pending_views[0];
        pending_views.delete(0);
        results_checked++;
        if (status_o !== exp_view.status) begin
          $error("status: expected %0d, got %0d", exp_view.status, status_o);
          fail_count++;
        end
        if (occupancy_o !== exp_view.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_view.occupancy, occupancy_o);
          fail_count++;
        end
        if (front_key_o !== exp_view.front_key) begin
          $error("front_key: expected %h, got %h", exp_view.front_key, front_key_o);
          fail_count++;
        end
        if (front_value_o !== exp_view.front_value) begin
          $error("front_value: expected %h, got %h", exp_view.front_value, front_value_o);
          fail_count++;
        end
        if (back_key_o !== exp_view.back_key) begin
          $error("back_key: expected %h, got %h", exp_view.back_key, back_key_o);
          fail_count++;
        end
        if (back_value_o !== exp_view.back_value) begin
          $error("back_value: expected %h, got %h", exp_view.back_value, back_value_o);
          fail_count++;
        end
        if (key_count_o !== exp_view.key_count) begin
          $error("key_count: expected %0d, got %0d", exp_view.key_count, key_count_o);
          fail_count++;
        end
        if (key_first_value_o !== exp_view.key_first_value) begin
          $error("key_first_value: expected %h, got %h", exp_view.key_first_value,
                 key_first_value_o);
          fail_count++;
        end
        if (key_last_value_o !== exp_view.key_last_value) begin
          $error("key_last_value: expected %h, got %h", exp_view.key_last_value,
                 key_last_value_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then phases of random actions.
  initial begin : stimulus
    logic [KW-1:0]               key_pool [4];
    logic [kfq_pkg::ActionW-1:0] act;
    logic [KW-1:0]               k;
    bit                          filling;
    int                          directed_count;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = kfq_pkg::ACT_QUERY;
    key_i        = '0;
    value_i      = '0;
    fail_count   = 0;
    actions_sent = 0;
    results_checked = 0;
    full_refusals = 0;
    key_misses   = 0;
    empty_pops   = 0;
    moves_done   = 0;
    source_calm  = 1'b0;
    mirror_fill  = 0;
    filling      = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      mirror_keys[i]   = '0;
      mirror_values[i] = '0;
    end

    // Empty queue first: every removal is refused, all fields read zero.
    add_row(kfq_pkg::ACT_QUERY, '0, '0, 1'b1,
            view_of(kfq_pkg::ST_OK, 0, '0, '0, '0, '0, 0, '0, '0));
    add_row(kfq_pkg::ACT_POP, 16'h1234, 32'hDEAD_BEEF, 1'b1,
            view_of(kfq_pkg::ST_EMPTY, 0, '0, '0, '0, '0, 0, '0, '0));
    add_row(kfq_pkg::ACT_POP_KEY, 16'hFFFF, '0, 1'b1,
            view_of(kfq_pkg::ST_MISSING, 0, '0, '0, '0, '0, 0, '0, '0));
    add_row(kfq_pkg::ACT_MOVE_KEY, 16'h0000, '0, 1'b1,
            view_of(kfq_pkg::ST_MISSING, 0, '0, '0, '0, '0, 0, '0, '0));
    add_row(kfq_pkg::ACT_CLEAR, '0, '0, 1'b1,
            view_of(kfq_pkg::ST_OK, 0, '0, '0, '0, '0, 0, '0, '0));
    add_row(kfq_pkg::ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
            view_of(kfq_pkg::ST_OK, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Four entries with a repeated key, then a query, moves, keyed and plain pops, spare codes and a clear.
    add_row(kfq_pkg::ACT_PUSH, 16'h0000, 32'h0000_0000, 1'b0, '0);
    add_row(kfq_pkg::ACT_PUSH, 16'hFFFF, 32'h1234_5678, 1'b0, '0);
    add_row(kfq_pkg::ACT_PUSH, 16'h0005, 32'hA5A5_A5A5, 1'b0, '0);
    add_row(kfq_pkg::ACT_PUSH, 16'hFFFF, 32'h5A5A_5A5A, 1'b0, '0);
    add_row(kfq_pkg::ACT_QUERY, 16'hFFFF, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_MOVE_KEY, 16'hFFFF, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_MOVE_KEY, 16'h0005, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_POP_KEY, 16'hFFFF, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_POP_KEY, 16'h7777, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_POP, '0, '0, 1'b0, '0);
    add_row(ACT_SPARE_A, 16'h0005, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ACT_SPARE_B, 16'h0000, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_CLEAR, '0, '0, 1'b0, '0);
    add_row(kfq_pkg::ACT_QUERY, 16'hFFFF, '0, 1'b1,
            view_of(kfq_pkg::ST_OK, 0, '0, '0, '0, '0, 0, '0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      send_action(stim_rows[i].action, stim_rows[i].key, stim_rows[i].value,
                  stim_rows[i].typed, stim_rows[i].view);
    end
    directed_count = actions_sent;

    // Random phases alternate between filling and draining with a fresh key pool.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        filling = ~filling;
        source_calm = ($urandom_range(0, 3) == 0);
        foreach (key_pool[j]) key_pool[j] = KW'($urandom);
      end
      act = pick_action(filling);
      if ($urandom_range(0, 9) == 0) k = KW'($urandom);
      else k = key_pool[$urandom_range(0, 3)];
      send_action(act, k, VW'($urandom), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result arrive, then watch for stray ones.
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d actions (%0d directed), checked %0d results, %0d moves to the back.",
             actions_sent, directed_count, results_checked, moves_done);
    $display("Refused: %0d pushes on a full queue, %0d missing keys, %0d pops when empty.",
             full_refusals, key_misses, empty_pops);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
hdl/kfq_pkg.sv
hdl/kfq_store.sv
hdl/kfq_tally.sv
hdl/keyed_fifo_queue_unit.sv
dv/tb_keyed_fifo_queue_unit.sv
